FILE: rtl/bgvs_pkg.sv
// Shared types, codes and sizes for the growable vector store.
`default_nettype none

package bgvs_pkg;

    // Physical depth and word width of the element store
    localparam int MAX_DEPTH  = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(MAX_DEPTH);

    // Count, capacity and register widths
    localparam int CNT_W = 11;
    localparam int IDX_W = 10;
    localparam int OP_W  = 2;
    localparam int ST_W  = 3;

    // Operation codes
    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_GET    = 2'd2;
    localparam logic [OP_W-1:0] OP_SET    = 2'd3;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [ST_W-1:0] ST_RANGE    = 3'd2;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd3;
    localparam logic [ST_W-1:0] ST_ALLOC    = 3'd4;

    // Configuration register indexes
    localparam logic REG_INIT_CAP = 1'b0;
    localparam logic REG_BLOCK    = 1'b1;

    // Reset values of the configuration registers
    localparam logic [CNT_W-1:0] INIT_CAP_RESET = 11'd16;
    localparam logic [CNT_W-1:0] BLOCK_RESET    = 11'd16;

    typedef struct packed {
        logic [OP_W-1:0]       opcode;
        logic [IDX_W-1:0]      index;
        logic [DATA_WIDTH-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [ST_W-1:0]       status;
        logic [DATA_WIDTH-1:0] read_value;
        logic [CNT_W-1:0]      element_count;
        logic [CNT_W-1:0]      current_capacity;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/bgvs_ram.sv
// Single-port synchronous RAM, read-first, with a registered read.
`default_nettype none

module bgvs_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write the addressed entry and register its old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

FILE: rtl/block_grow_vector_store.sv
// Top level of the growable vector store: control, counters and result stage.
`default_nettype none

// Growable vector of 32-bit words over a 1024-entry single-port RAM. An
// operation is taken on any cycle start is high; busy stays low, so one
// operation per cycle is sustained. Its result appears in the cycle right
// after the accepting edge with done high for exactly one cycle; the receiver
// cannot stall and must take it then. Count and capacity are updated at the
// accepting edge, so the next operation sees them at once. A write to
// initial_capacity clears the vector (count zero) and takes effect at once;
// no clearing pass is run. Write configuration only in a cycle with start
// low and no result pending.

module block_grow_vector_store
    import bgvs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire cmd_t             cmd,
    output logic                  done,
    output result_t               result,
    input  wire logic             wr_en,
    input  wire logic             wr_index,
    input  wire logic [CNT_W-1:0] wr_data
);

    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(MAX_DEPTH);
    localparam logic [CNT_W:0]   DEPTH_CW = (CNT_W + 1)'(MAX_DEPTH);

    // Configuration and counters
    logic [CNT_W-1:0] init_cap_reg;
    logic [CNT_W-1:0] block_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cap_reg, cap_next;

    // Result stage
    logic             done_reg;
    logic [ST_W-1:0]  res_status_reg, res_status_next;
    logic [CNT_W-1:0] res_count_reg;
    logic [CNT_W-1:0] res_cap_reg;
    logic             res_rd_sel_reg, res_rd_sel_next;

    // RAM port
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_addr;
    logic [DATA_WIDTH-1:0] ram_q;

    // Datapath helpers
    logic [CNT_W:0]   grown;
    logic [CNT_W:0]   twice;
    logic [CNT_W:0]   cap_wide;
    logic [CNT_W:0]   cap_less_twice;
    logic [CNT_W-1:0] count_dec;
    logic             shrink;
    logic             idx_ok;
    logic [CNT_W-1:0] init_sat;

    assign busy = 1'b0;

    assign grown          = {1'b0, cap_reg} + {1'b0, block_reg};
    assign twice          = {block_reg, 1'b0};
    assign cap_wide       = {1'b0, cap_reg};
    assign cap_less_twice = cap_wide - twice;
    assign count_dec      = count_reg - 1'b1;
    assign idx_ok         = {1'b0, cmd.index} < count_reg;
    assign init_sat       = (wr_data > DEPTH_C) ? DEPTH_C : wr_data;

    // Shrink test after a pop, on the decremented count
    assign shrink = (cap_reg > init_cap_reg)
                 && ((twice > cap_wide) || ({1'b0, count_dec} < cap_less_twice))
                 && (block_reg <= cap_reg);

    // Decode the operation: status, counter updates and RAM access
    always_comb
    begin
        count_next      = count_reg;
        cap_next        = cap_reg;
        res_status_next = ST_OK;
        res_rd_sel_next = 1'b0;
        ram_we          = 1'b0;
        ram_addr        = cmd.index[ADDR_W-1:0];
        case (cmd.opcode)
            OP_APPEND:
            begin
                ram_addr = count_reg[ADDR_W-1:0];
                if (count_reg >= DEPTH_C)
                begin
                    res_status_next = ST_ALLOC;
                end
                else if (count_reg >= cap_reg && block_reg == '0)
                begin
                    res_status_next = ST_OVERFLOW;
                end
                else if (count_reg >= cap_reg && grown > DEPTH_CW)
                begin
                    res_status_next = ST_ALLOC;
                end
                else
                begin
                    if (count_reg >= cap_reg)
                    begin
                        cap_next = grown[CNT_W-1:0];
                    end
                    ram_we     = start;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                ram_addr = count_dec[ADDR_W-1:0];
                if (count_reg == '0)
                begin
                    res_status_next = ST_EMPTY;
                end
                else
                begin
                    count_next      = count_dec;
                    res_rd_sel_next = 1'b1;
                    if (shrink)
                    begin
                        cap_next = cap_reg - block_reg;
                    end
                end
            end
            OP_GET:
            begin
                if (!idx_ok)
                begin
                    res_status_next = ST_RANGE;
                end
                else
                begin
                    res_rd_sel_next = 1'b1;
                end
            end
            OP_SET:
            begin
                if (!idx_ok)
                begin
                    res_status_next = ST_RANGE;
                end
                else
                begin
                    ram_we = start;
                end
            end
            default:
            begin
                res_status_next = ST_OK;
            end
        endcase
    end

    // Element store
    bgvs_ram #(
        .DEPTH (MAX_DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (cmd.value),
        .rdata (ram_q)
    );

    // Advance counters on an accepted operation; an initial capacity write clears
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cap_reg <= INIT_CAP_RESET;
            block_reg    <= BLOCK_RESET;
            count_reg    <= '0;
            cap_reg      <= INIT_CAP_RESET;
        end
        else if (wr_en)
        begin
            if (wr_index == REG_INIT_CAP)
            begin
                init_cap_reg <= init_sat;
                count_reg    <= '0;
                cap_reg      <= init_sat;
            end
            else
            begin
                block_reg <= wr_data;
            end
        end
        else if (start)
        begin
            count_reg <= count_next;
            cap_reg   <= cap_next;
        end
    end

    // Strobe the result in the cycle after the transfer in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    // Hold the result fields alongside the RAM read
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            res_status_reg <= res_status_next;
            res_rd_sel_reg <= res_rd_sel_next;
            res_count_reg  <= count_next;
            res_cap_reg    <= cap_next;
        end
    end

    assign done                    = done_reg;
    assign result.status           = res_status_reg;
    assign result.read_value       = res_rd_sel_reg ? ram_q : '0;
    assign result.element_count    = res_count_reg;
    assign result.current_capacity = res_cap_reg;

    // Every accepted operation yields exactly one result next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> done)
        else $error("result strobe missing after accepted operation");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start))
        else $error("result strobe without an operation");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C && cap_reg <= DEPTH_C)
        else $error("count or capacity beyond physical depth");

    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        start && !wr_en && cmd.opcode == OP_APPEND |=>
            (result.status == ST_OK) == (count_reg == $past(count_reg) + 1'b1))
        else $error("append status disagrees with count change");

endmodule

`default_nettype wire
